@@ design/dda_pkg.sv @@
package dda_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic advance;
  } axis_ctrl_t;

endpackage

@@ design/dda_div.sv @@
module dda_div #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] span,
  input  logic [COORD_BITS-1:0] divisor,
  input  logic                  neg,
  output logic                  done,
  output logic [FRAC_BITS+1:0]  increment
);

  localparam int CNT_BITS = $clog2(FRAC_BITS + 2);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [COORD_BITS:0]   rem;
  logic [COORD_BITS-1:0] dvs;
  logic [FRAC_BITS:0]    quo;
  logic                  sign;
  logic [COORD_BITS:0]   diff;
  logic                  qbit;
  logic [COORD_BITS:0]   rem_next;
  logic [FRAC_BITS+1:0]  mag;

  // One quotient bit per cycle, shifting a zero into the partial remainder.
  always_comb begin
    diff     = rem - {1'b0, dvs};
    qbit     = (rem >= {1'b0, dvs});
    rem_next = qbit ? diff : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(FRAC_BITS + 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, span};
      dvs  <= divisor;
      quo  <= '0;
      sign <= neg;
    end else if (busy) begin
      rem <= {rem_next[COORD_BITS-1:0], 1'b0};
      quo <= {quo[FRAC_BITS-1:0], qbit};
    end
  end

  assign mag       = {1'b0, quo};
  assign increment = sign ? (~mag + 1'b1) : mag;

endmodule

@@ design/dda_axis.sv @@
module dda_axis #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dda_pkg::axis_ctrl_t   ctrl,
  input  logic [COORD_BITS-1:0] coord_start,
  input  logic [COORD_BITS-1:0] coord_end,
  input  logic [COORD_BITS-1:0] divisor,
  output logic                  div_done,
  output logic [COORD_BITS-1:0] coord
);

  localparam int ACC_BITS = COORD_BITS + FRAC_BITS;
  localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

  logic [ACC_BITS-1:0]    acc;
  logic [FRAC_BITS+1:0]   inc;
  logic [FRAC_BITS+1:0]   div_inc;
  logic                   neg;
  logic [COORD_BITS-1:0]  span;
  logic [ACC_BITS-1:0]    inc_ext;
  logic [ACC_BITS-1:0]    rounded;

  assign neg     = (coord_end < coord_start);
  assign span    = neg ? (coord_start - coord_end) : (coord_end - coord_start);
  assign inc_ext = {{(COORD_BITS - 2){inc[FRAC_BITS+1]}}, inc};
  assign rounded = acc + HALF;
  assign coord   = rounded[ACC_BITS-1:FRAC_BITS];

  dda_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.start),
    .span     (span),
    .divisor  (divisor),
    .neg      (neg),
    .done     (div_done),
    .increment(div_inc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      inc <= '0;
    end else begin
      if (ctrl.load) begin
        acc <= {coord_start, {FRAC_BITS{1'b0}}};
        inc <= '0;
      end else if (ctrl.advance) begin
        acc <= acc + inc_ext;
      end
      if (div_done) begin
        inc <= div_inc;
      end
    end
  end

endmodule

@@ design/dda_line_point_generator.sv @@
// Step request: no new request is taken until WAIT writes the result out.
// Load request: DIV waits for the bit-serial dividers, one per axis, each of which
// produces one quotient bit per cycle; a zero-length line skips DIV and the dividers.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous and active high; it clears the line state and out_valid.
module dda_line_point_generator #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  point_valid,
  output logic [COORD_BITS-1:0] point_x,
  output logic [COORD_BITS-1:0] point_y,
  output logic                  last_point,
  output logic [COORD_BITS-1:0] step_total
);

  localparam logic [1:0] STATE_IDLE = 2'd0;
  localparam logic [1:0] STATE_DIV  = 2'd1;
  localparam logic [1:0] STATE_WAIT = 2'd2;

  logic [1:0]            state;
  logic [COORD_BITS-1:0] steps;
  logic                  op_held;
  logic                  active_held;
  logic                  accept;
  logic                  out_free;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic [COORD_BITS-1:0] n;
  logic                  x_done;
  logic                  y_done;
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] y_coord;
  dda_pkg::axis_ctrl_t   ctrl;

  assign in_stall = (state != STATE_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign adx = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
  assign ady = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);
  assign n   = (adx >= ady) ? adx : ady;

  always_comb begin
    ctrl.load    = accept && (op == dda_pkg::OP_LOAD);
    ctrl.start   = ctrl.load && (n != '0);
    ctrl.advance = accept && (op == dda_pkg::OP_STEP) && (steps != '0);
  end

  dda_axis #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_x (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .coord_start(x_start),
    .coord_end  (x_end),
    .divisor    (n),
    .div_done   (x_done),
    .coord      (x_coord)
  );

  dda_axis #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_y (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .coord_start(y_start),
    .coord_end  (y_end),
    .divisor    (n),
    .div_done   (y_done),
    .coord      (y_coord)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= STATE_IDLE;
      steps       <= '0;
      op_held     <= dda_pkg::OP_LOAD;
      active_held <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == STATE_WAIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        STATE_IDLE: begin
          if (accept) begin
            op_held <= op;
            if (op == dda_pkg::OP_LOAD) begin
              steps <= n;
              state <= (n == '0) ? STATE_WAIT : STATE_DIV;
            end else begin
              active_held <= (steps != '0);
              if (steps != '0) begin
                steps <= steps - 1'b1;
              end
              state <= STATE_WAIT;
            end
          end
        end
        STATE_DIV: begin
          if (x_done) begin
            state <= STATE_WAIT;
          end
        end
        STATE_WAIT: begin
          if (out_free) begin
            state <= STATE_IDLE;
          end
        end
        default: begin
          state <= STATE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == STATE_WAIT && out_free) begin
      if (op_held == dda_pkg::OP_LOAD) begin
        point_valid <= 1'b0;
        point_x     <= '0;
        point_y     <= '0;
        last_point  <= 1'b0;
        step_total  <= steps;
      end else if (active_held) begin
        point_valid <= 1'b1;
        point_x     <= x_coord;
        point_y     <= y_coord;
        last_point  <= (steps == '0);
        step_total  <= '0;
      end else begin
        point_valid <= 1'b0;
        point_x     <= '0;
        point_y     <= '0;
        last_point  <= 1'b0;
        step_total  <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    (x_done || y_done) |-> (state == STATE_DIV && x_done == y_done))
    else $error("divider finished outside of a load");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != STATE_IDLE))
    else $error("accepted request did not occupy the block");

  a_point_no_total: assert property (@(posedge clk) disable iff (rst)
    (out_valid && point_valid) |-> (step_total == '0))
    else $error("point result carries a step count");
`endif

endmodule
